/* src/pnm_pixel_byte_encoder_macros.svh */
// Assertion macros used by the netpbm byte encoder checker
`ifndef PNM_PIXEL_BYTE_ENCODER_MACROS_SVH
`define PNM_PIXEL_BYTE_ENCODER_MACROS_SVH

// Clocked assertion, muted while reset is held
`define PBE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds during reset
`define PBE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/pbe_pkg.sv */
// Types, codes and constant tables of the netpbm pixel byte encoder
`timescale 1ns / 1ps

package pbe_pkg;

    // pixel format codes
    localparam logic [1:0] FMT_COLOUR = 2'd0;
    localparam logic [1:0] FMT_GREY   = 2'd1;
    localparam logic [1:0] FMT_BITMAP = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] REG_TEXT_MODE    = 2'd1;
    localparam logic [1:0] REG_WIDE_SAMPLES = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;

    // characters of the text body
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_ONE   = 8'h31;
    localparam logic [7:0] ASCII_SPACE = 8'h20;

    localparam logic [7:0] BIT_THRESHOLD = 8'd127;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // decimal digits of a 16-bit sample
    localparam int DEC_DIGITS = 5;

    typedef struct packed {
        logic [1:0] pixel_format;
        logic       text_mode;
        logic       wide_samples;
    } cfg_t;

    // one step of the sequencer toward the output register
    typedef struct packed {
        logic       load;
        logic [7:0] data;
        logic       last;
        logic       done;
    } step_t;

    // packed bitmap byte offered by the bit packer
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
    } pack_t;

    function automatic int pow10(input int k);
        int p;
        p = 1;
        for (int i = 0; i < k; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    // j times ten to the k, for constant k and j
    function automatic logic [16:0] dec_step(input int k, input int j);
        return 17'(pow10(k) * j);
    endfunction

    // count of decimal digits, without leading zeros
    function automatic logic [2:0] num_digits(input logic [15:0] v);
        logic [2:0] n;
        n = 3'd1;
        if (v >= 16'd10)    n = 3'd2;
        if (v >= 16'd100)   n = 3'd3;
        if (v >= 16'd1000)  n = 3'd4;
        if (v >= 16'd10000) n = 3'd5;
        return n;
    endfunction

endpackage

/* src/pbe_digit.sv */
// Decimal digit extractor: one digit of a value at a given power of ten
`timescale 1ns / 1ps

module pbe_digit (
    input  logic [15:0] value,
    input  logic [2:0]  pos,
    output logic [3:0]  digit,
    output logic [15:0] remainder
);
    import pbe_pkg::*;

    logic [8:0]  ge [DEC_DIGITS];
    logic [16:0] sub_amt;

    // compare against every multiple of every power in parallel
    always_comb
    begin
        for (int k = 0; k < DEC_DIGITS; k++)
        begin
            for (int j = 1; j <= 9; j++)
            begin
                ge[k][j-1] = {1'b0, value} >= dec_step(k, j);
            end
        end
    end

    // pick the largest multiple that fits at the selected power
    always_comb
    begin
        digit   = 4'd0;
        sub_amt = 17'd0;
        for (int k = 0; k < DEC_DIGITS; k++)
        begin
            if (pos == 3'(k))
            begin
                for (int j = 1; j <= 9; j++)
                begin
                    if (ge[k][j-1])
                    begin
                        digit   = 4'(j);
                        sub_amt = dec_step(k, j);
                    end
                end
            end
        end
    end

    assign remainder = 16'({1'b0, value} - sub_amt);

endmodule

/* src/pbe_bitpack.sv */
// Bit packer for binary bitmap output, MSB first, padded at row end
`timescale 1ns / 1ps

module pbe_bitpack (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pix_bit,
    input  logic          row_end,
    input  logic          commit,
    output pbe_pkg::pack_t pack
);
    import pbe_pkg::*;

    logic [7:0] acc_reg, acc_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] acc;
    logic [3:0] cnt;
    logic       full;

    // shift in the new bit and see whether a byte goes out
    always_comb
    begin
        acc  = {acc_reg[6:0], pix_bit};
        cnt  = {1'b0, cnt_reg} + 4'd1;
        full = cnt >= BITS_PER_BYTE;
        pack.emit = full || row_end;
        if (full)
            pack.data = acc;
        else
            pack.data = 8'(acc << (BITS_PER_BYTE - cnt));
    end

    // keep the partial byte, or drop it once written
    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (commit)
        begin
            if (pack.emit)
            begin
                acc_next = 8'd0;
                cnt_next = 3'd0;
            end
            else
            begin
                acc_next = acc;
                cnt_next = cnt[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 8'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* src/pbe_seq.sv */
// Byte sequencer: walks the samples of the held pixel and picks each byte
`timescale 1ns / 1ps

module pbe_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  pbe_pkg::cfg_t cfg,
    input  logic          pix_valid,
    input  logic [15:0]   first_sample,
    input  logic [15:0]   second_sample,
    input  logic [15:0]   third_sample,
    input  logic          row_end,
    input  logic          out_space,
    output pbe_pkg::step_t step
);
    import pbe_pkg::*;

    logic [1:0]  sidx_reg, sidx_next;
    logic [2:0]  sub_reg, sub_next;
    logic [15:0] rem_reg, rem_next;

    logic [15:0] samp;
    logic [15:0] cur_val;
    logic [7:0]  top;
    logic        pix_bit;
    logic [2:0]  ndig;
    logic [2:0]  pos;
    logic [3:0]  digit;
    logic [15:0] dig_rem;
    logic        packed_mode;
    logic [1:0]  last_idx;
    logic        emit;
    logic        samp_last;
    logic        item_last;
    logic [7:0]  data;
    logic        advance;
    logic        done;
    pack_t       pack;

    // select the current sample and trim it to the sample width
    always_comb
    begin
        case (sidx_reg)
            2'd0:    samp = first_sample;
            2'd1:    samp = second_sample;
            default: samp = third_sample;
        endcase
        if (!cfg.wide_samples)
            samp = {8'd0, samp[7:0]};
    end

    assign top     = cfg.wide_samples ? samp[15:8] : samp[7:0];
    assign pix_bit = top > BIT_THRESHOLD;

    assign cur_val  = (sub_reg == 3'd0) ? samp : rem_reg;
    assign ndig     = num_digits(samp);
    assign pos      = ndig - 3'd1 - sub_reg;
    assign last_idx = (cfg.pixel_format == FMT_COLOUR) ? 2'd2 : 2'd0;

    assign packed_mode = (cfg.pixel_format == FMT_BITMAP) && !cfg.text_mode;

    pbe_digit u_digit (
        .value     (cur_val),
        .pos       (pos),
        .digit     (digit),
        .remainder (dig_rem)
    );

    pbe_bitpack u_bitpack (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_bit (pix_bit),
        .row_end (row_end),
        .commit  (done && packed_mode),
        .pack    (pack)
    );

    // choose the byte for the current step
    always_comb
    begin
        emit      = 1'b1;
        data      = 8'd0;
        samp_last = 1'b0;
        if (packed_mode)
        begin
            emit      = pack.emit;
            data      = pack.data;
            samp_last = 1'b1;
        end
        else if (cfg.pixel_format == FMT_BITMAP)
        begin
            if (sub_reg == 3'd0)
                data = pix_bit ? ASCII_ONE : ASCII_ZERO;
            else
            begin
                data      = ASCII_SPACE;
                samp_last = 1'b1;
            end
        end
        else if (cfg.text_mode)
        begin
            if (sub_reg == ndig)
            begin
                data      = ASCII_SPACE;
                samp_last = 1'b1;
            end
            else
                data = ASCII_ZERO + {4'd0, digit};
        end
        else if (cfg.wide_samples)
        begin
            if (sub_reg == 3'd0)
                data = samp[15:8];
            else
            begin
                data      = samp[7:0];
                samp_last = 1'b1;
            end
        end
        else
        begin
            data      = samp[7:0];
            samp_last = 1'b1;
        end
    end

    assign item_last = samp_last && (packed_mode || sidx_reg == last_idx);
    assign advance   = pix_valid && emit && out_space;
    assign done      = pix_valid && (!emit || (out_space && item_last));

    assign step.load = advance;
    assign step.data = data;
    assign step.last = item_last;
    assign step.done = done;

    // advance through bytes and samples, restart when the pixel leaves
    always_comb
    begin
        sidx_next = sidx_reg;
        sub_next  = sub_reg;
        rem_next  = rem_reg;
        if (done)
        begin
            sidx_next = 2'd0;
            sub_next  = 3'd0;
        end
        else if (advance)
        begin
            if (samp_last)
            begin
                sidx_next = sidx_reg + 2'd1;
                sub_next  = 3'd0;
            end
            else
            begin
                sub_next = sub_reg + 3'd1;
                rem_next = dig_rem;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sidx_reg <= 2'd0;
            sub_reg  <= 3'd0;
        end
        else
        begin
            sidx_reg <= sidx_next;
            sub_reg  <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

endmodule

/* src/pnm_pixel_byte_encoder.sv */
// Netpbm raster body encoder: one pixel in, its body bytes out
//
//  channel   signals                                          accepted when
//  pixel     in_valid in_ready first/second/third_sample       in_valid & in_ready
//            row_end
//  byte      out_valid out_ready out_byte last_byte            out_valid & out_ready
//  config    cfg_we cfg_index cfg_data                         cfg_we
//
//  One byte leaves per cycle while the output is not stalled, set by the single
//  output register; a pixel has 0 to 18 bytes (6 for binary 16-bit colour).
//  A binary bitmap pixel that completes no byte passes without loading one.
//  The next pixel is taken in the cycle its predecessor's last byte is loaded.
//  Reset clears the configuration, the packed bits and both valid flags.
//  A stalled output holds its byte and stops the sequencer in place.
`timescale 1ns / 1ps

module pnm_pixel_byte_encoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pbe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pbe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [15:0]                    first_sample,
    input  logic [15:0]                    second_sample,
    input  logic [15:0]                    third_sample,
    input  logic                           row_end,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     out_byte,
    output logic                           last_byte
);
    import pbe_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic        pix_valid_reg, pix_valid_next;
    logic [15:0] first_reg, second_reg, third_reg;
    logic        row_end_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        last_byte_reg;
    logic        out_space;
    logic        in_load;
    step_t       step;

    // decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PIXEL_FORMAT: cfg_next.pixel_format = cfg_data[1:0];
                REG_TEXT_MODE:    cfg_next.text_mode    = cfg_data[0];
                REG_WIDE_SAMPLES: cfg_next.wide_samples = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // hold the pixel until its last byte is loaded
    assign out_space = !out_valid_reg || out_ready;
    assign in_ready  = !pix_valid_reg || step.done;
    assign in_load   = in_valid && in_ready;

    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        if (in_load)
            pix_valid_next = 1'b1;
        else if (step.done)
            pix_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= 1'b0;
        else
            pix_valid_reg <= pix_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            first_reg   <= first_sample;
            second_reg  <= second_sample;
            third_reg   <= third_sample;
            row_end_reg <= row_end;
        end
    end

    pbe_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .pix_valid     (pix_valid_reg),
        .first_sample  (first_reg),
        .second_sample (second_reg),
        .third_sample  (third_reg),
        .row_end       (row_end_reg),
        .out_space     (out_space),
        .step          (step)
    );

    // output register: load a word, drop valid once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step.load)
        begin
            out_byte_reg  <= step.data;
            last_byte_reg <= step.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_byte_reg;

endmodule

/* src/pbe_checker.sv */
// Port checker for the netpbm pixel byte encoder, bound to the top level
`timescale 1ns / 1ps
`include "pnm_pixel_byte_encoder_macros.svh"

module pbe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_byte
);

    logic seen_in_reg;

    // note that some pixel has entered since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_in_reg <= 1'b0;
        else if (in_valid && in_ready)
            seen_in_reg <= 1'b1;
    end

    `PBE_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte), "stalled word changed")
    `PBE_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "word offered during reset")
    `PBE_ASSERT(a_no_invented, clk, rst_n, out_valid |-> seen_in_reg, "word offered before any pixel")
    `PBE_ASSERT(a_no_bubble, clk, rst_n, out_valid && out_ready && !last_byte |=> out_valid, "gap inside a pixel's bytes")

endmodule

bind pnm_pixel_byte_encoder pbe_checker u_pbe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_byte (last_byte)
);
